// File: rtl/rsob_pkg.sv
// ----------------------------------------------------------------------------
// rsob_pkg
// Shared types, constants and the divider step for the RGBA source-over blend.
// ----------------------------------------------------------------------------
package rsob_pkg;

  localparam int unsigned ChanNum       = 3;
  localparam int unsigned ChanWidth     = 8;
  localparam int unsigned PixelWidth    = 32;
  localparam int unsigned DenWidth      = 16;
  localparam int unsigned DivSteps      = 8;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned DivStages     = DivSteps / StepsPerStage;
  localparam int unsigned AlphaLsb      = 24;

  localparam logic [ChanWidth-1:0] AlphaClear  = 8'h00;
  localparam logic [ChanWidth-1:0] AlphaOpaque = 8'hff;

  // Partial remainder and combined numerator-low-bits / quotient shifter
  typedef struct packed {
    logic [DenWidth-1:0] prem;
    logic [DenWidth-1:0] nq;
  } rsob_step_t;

  // One request as it travels through the divider stages
  typedef struct packed {
    logic                      last;
    logic                      bypass;
    logic [PixelWidth-1:0]     pass_pixel;
    logic [DenWidth-1:0]       den;
    rsob_step_t [ChanNum-1:0]  ch;
  } rsob_div_t;

  // One restoring division step: shift in the next numerator bit, try to
  // subtract the divisor, and shift the quotient bit into the low end.
  function automatic rsob_step_t rsob_div_step(input rsob_step_t s,
                                               input logic [DenWidth-1:0] den);
    logic [DenWidth:0] trial;
    rsob_step_t        r;
    trial = {s.prem, s.nq[DenWidth-1]};
    r.nq  = {s.nq[DenWidth-2:0], 1'b0};
    if (trial >= {1'b0, den}) begin
      r.prem  = DenWidth'(trial - {1'b0, den});
      r.nq[0] = 1'b1;
    end else begin
      r.prem = trial[DenWidth-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/rsob_prep.sv
// ----------------------------------------------------------------------------
// rsob_prep
// Two pipeline stages that premultiply the destination and form the blend
// numerators and the combined-alpha divisor.
// ----------------------------------------------------------------------------
module rsob_prep import rsob_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [PixelWidth-1:0] dest_pixel_i,
  input  logic [PixelWidth-1:0] over_pixel_i,
  input  logic                  last_pixel_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output rsob_div_t             data_o
);

  typedef struct packed {
    logic                                last;
    logic                                bypass;
    logic [PixelWidth-1:0]               pass_pixel;
    logic [ChanWidth-1:0]                a1;
    logic [ChanWidth:0]                  inv;
    logic [ChanNum-1:0][ChanWidth-1:0]   c1;
    logic [ChanNum-1:0][2*ChanWidth-1:0] c0p;
    logic [2*ChanWidth:0]                ad;
  } prep_t;

  prep_t     st_a_d, st_a_q;
  rsob_div_t st_b_d, st_b_q;
  logic      valid_a_q, valid_b_q;
  logic      ready_a, ready_b;

  // Stall chain: a stage loads when empty or when its successor drains it
  assign ready_b = !valid_b_q || ready_i;
  assign ready_a = !valid_a_q || ready_b;
  assign ready_o = ready_a;

  // Stage A: premultiply destination colour, pick the bypass pixel
  always_comb begin
    logic [ChanWidth-1:0] a0;
    a0               = dest_pixel_i[AlphaLsb +: ChanWidth];
    st_a_d.a1        = over_pixel_i[AlphaLsb +: ChanWidth];
    st_a_d.last      = last_pixel_i;
    st_a_d.bypass    = (st_a_d.a1 == AlphaClear) || (st_a_d.a1 == AlphaOpaque);
    st_a_d.pass_pixel = (st_a_d.a1 == AlphaClear) ? dest_pixel_i : over_pixel_i;
    st_a_d.inv       = (ChanWidth+1)'(9'd256 - {1'b0, st_a_d.a1});
    st_a_d.ad        = (2*ChanWidth+1)'(17'(a0) * 17'(st_a_d.inv));
    for (int c = 0; c < ChanNum; c++) begin
      st_a_d.c1[c]  = over_pixel_i[c*ChanWidth +: ChanWidth];
      st_a_d.c0p[c] = 16'(dest_pixel_i[c*ChanWidth +: ChanWidth]) * 16'(a0);
    end
  end

  // Stage B: numerator 256*c1*a1 + c0p*(256-a1), divisor 256*a1 + a0*(256-a1)
  always_comb begin
    logic [16:0] den_sum;
    logic [25:0] num;
    den_sum           = {1'b0, st_a_q.a1, 8'h00} + st_a_q.ad;
    st_b_d.last       = st_a_q.last;
    st_b_d.bypass     = st_a_q.bypass;
    st_b_d.pass_pixel = st_a_q.pass_pixel;
    st_b_d.den        = den_sum[DenWidth-1:0];
    for (int c = 0; c < ChanNum; c++) begin
      num = 26'({16'(st_a_q.c1[c]) * 16'(st_a_q.a1), 8'h00})
          + 26'(26'(st_a_q.c0p[c]) * 26'(st_a_q.inv));
      // quotient stays below 256, so numerator >> 8 is below the divisor
      st_b_d.ch[c].prem = num[23:8];
      st_b_d.ch[c].nq   = {num[7:0], 8'h00};
    end
  end

  // Hold valid bits under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (ready_a) valid_a_q <= valid_i;
      if (ready_b) valid_b_q <= valid_a_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i)   st_a_q <= st_a_d;
    if (ready_b && valid_a_q) st_b_q <= st_b_d;
  end

  assign valid_o = valid_b_q;
  assign data_o  = st_b_q;

endmodule

// File: rtl/rsob_div_stage.sv
// ----------------------------------------------------------------------------
// rsob_div_stage
// One pipeline stage of the restoring divider; retires two quotient bits for
// each colour channel.
// ----------------------------------------------------------------------------
module rsob_div_stage import rsob_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  rsob_div_t data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output rsob_div_t data_o
);

  rsob_div_t data_d, data_q;
  logic      valid_q;

  assign ready_o = !valid_q || ready_i;

  // Run the division steps of this stage on every channel
  always_comb begin
    data_d = data_i;
    for (int c = 0; c < ChanNum; c++) begin
      for (int s = 0; s < StepsPerStage; s++) begin
        data_d.ch[c] = rsob_div_step(data_d.ch[c], data_i.den);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Advance payload on load
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/rgba_source_over_blend_unit.sv
// ----------------------------------------------------------------------------
// rgba_source_over_blend_unit
// Source-over compositing of an RGBA8 overlay pixel onto an RGBA8 destination.
// ----------------------------------------------------------------------------
// Takes one pixel pair per cycle and returns one composited pixel per cycle
// while the output is not stalled. Two stages premultiply and form the
// numerators and the combined alpha; four more stages run an eight-step
// restoring divider, two quotient bits per stage, for the three colour
// channels in parallel. An overlay alpha of 0 or 255 rides the same pipeline
// and returns the destination or the overlay unchanged. The last-pixel mark
// travels with its pixel. Each stage loads whenever it is empty or drained,
// so bubbles close up under an output stall.
module rgba_source_over_blend_unit import rsob_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PixelWidth-1:0] dest_pixel_i,
  input  logic [PixelWidth-1:0] over_pixel_i,
  input  logic                  last_pixel_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PixelWidth-1:0] blended_pixel_o,
  output logic                  last_out_o
);

  rsob_div_t stage_data  [DivStages+1];
  logic      stage_valid [DivStages+1];
  logic      stage_ready [DivStages+1];

  // Premultiply and form numerator / divisor
  rsob_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i),
    .ready_o      (in_ready_o),
    .dest_pixel_i (dest_pixel_i),
    .over_pixel_i (over_pixel_i),
    .last_pixel_i (last_pixel_i),
    .valid_o      (stage_valid[0]),
    .ready_i      (stage_ready[0]),
    .data_o       (stage_data[0])
  );

  // Divider pipeline
  for (genvar g = 0; g < DivStages; g++) begin : g_div
    rsob_div_stage u_div_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[g]),
      .ready_o (stage_ready[g]),
      .data_i  (stage_data[g]),
      .valid_o (stage_valid[g+1]),
      .ready_i (stage_ready[g+1]),
      .data_o  (stage_data[g+1])
    );
  end

  assign stage_ready[DivStages] = out_ready_i;

  // Assemble the result: bypass pixel or blended channels with D >> 8 alpha
  assign out_valid_o     = stage_valid[DivStages];
  assign last_out_o      = stage_data[DivStages].last;
  assign blended_pixel_o = stage_data[DivStages].bypass
                         ? stage_data[DivStages].pass_pixel
                         : {stage_data[DivStages].den[DenWidth-1:ChanWidth],
                            stage_data[DivStages].ch[2].nq[ChanWidth-1:0],
                            stage_data[DivStages].ch[1].nq[ChanWidth-1:0],
                            stage_data[DivStages].ch[0].nq[ChanWidth-1:0]};

  // Input is refused only when the whole pipeline is backed up
  a_refuse_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input refused while pipeline has room");

  // Divider entry: quotient must fit in eight bits
  a_div_entry_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid[0] && !stage_data[0].bypass) |->
      (stage_data[0].ch[0].prem < stage_data[0].den) &&
      (stage_data[0].ch[1].prem < stage_data[0].den) &&
      (stage_data[0].ch[2].prem < stage_data[0].den))
    else $error("divider entry remainder not below divisor");

  // Divider exit: final remainders are proper
  a_div_exit_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !stage_data[DivStages].bypass) |->
      (stage_data[DivStages].ch[0].prem < stage_data[DivStages].den) &&
      (stage_data[DivStages].ch[1].prem < stage_data[DivStages].den) &&
      (stage_data[DivStages].ch[2].prem < stage_data[DivStages].den))
    else $error("divider exit remainder not below divisor");

  // Blended alpha is never zero
  a_blend_alpha_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !stage_data[DivStages].bypass) |->
      (blended_pixel_o[PixelWidth-1:AlphaLsb] != AlphaClear))
    else $error("blended alpha is zero");

endmodule
